// File: hw/rtl/cmsf_pkg.sv
// Shared constants, control structs and state type for the circular median scan filter.
// Used by cmsf_ctrl, cmsf_dp and circular_median5_scan_filter.
package cmsf_pkg;

    localparam int MAX_RAYS    = 64;
    localparam int MIN_RAYS    = 5;
    localparam int HALF_WINDOW = 2;
    localparam int WIN_LEN     = 2 * HALF_WINDOW + 1;

    localparam int SAMPLE_W = 16;
    localparam int ADDR_W   = $clog2(MAX_RAYS);
    localparam int CNT_W    = $clog2(MAX_RAYS + 1);
    localparam int LEFT_W   = $clog2(MAX_RAYS + WIN_LEN);
    localparam int WC_W     = $clog2(WIN_LEN + 1);
    localparam int RANK_W   = $clog2(WIN_LEN);

    localparam logic [CNT_W-1:0] RAY_COUNT_RESET = CNT_W'(50);

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_DRAIN
    } cmsf_state_t;

    // controller to datapath
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              scan_start;
    } cmsf_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [CNT_W-1:0] scan_len;
        logic             adv;
        logic             last_xfer;
    } cmsf_stat_t;

endpackage

// File: hw/rtl/cmsf_ctrl.sv
// Controller of the circular median scan filter: load counter, read sequencer, state machine.
// Depends on cmsf_pkg; drives cmsf_dp through cmsf_cmd_t.
module cmsf_ctrl
    import cmsf_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  cmsf_stat_t stat,
    output cmsf_cmd_t  cmd
);

    cmsf_state_t       state_reg, state_next;
    logic [ADDR_W-1:0] load_cnt_reg, load_cnt_next;
    logic [ADDR_W-1:0] rd_addr_reg, rd_addr_next;
    logic [LEFT_W-1:0] rd_left_reg, rd_left_next;
    logic              accept;
    logic              complete;

    assign complete = (CNT_W'(load_cnt_reg) + CNT_W'(1)) >= stat.scan_len;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_LOAD;
            load_cnt_reg <= '0;
            rd_addr_reg  <= '0;
            rd_left_reg  <= '0;
        end else begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            rd_addr_reg  <= rd_addr_next;
            rd_left_reg  <= rd_left_next;
        end
    end

    always_comb begin
        state_next     = state_reg;
        load_cnt_next  = load_cnt_reg;
        rd_addr_next   = rd_addr_reg;
        rd_left_next   = rd_left_reg;
        s_ready        = 1'b0;
        accept         = 1'b0;
        cmd.wr_en      = 1'b0;
        cmd.wr_addr    = load_cnt_reg;
        cmd.rd_en      = 1'b0;
        cmd.rd_addr    = rd_addr_reg;
        cmd.scan_start = 1'b0;

        unique case (state_reg)
            ST_LOAD: begin
                s_ready   = 1'b1;
                accept    = s_valid;
                cmd.wr_en = accept;
                if (accept) begin
                    if (complete) begin
                        // window for ray 0 starts HALF_WINDOW entries before the end
                        cmd.scan_start = 1'b1;
                        load_cnt_next  = '0;
                        rd_addr_next   = ADDR_W'(stat.scan_len - CNT_W'(HALF_WINDOW));
                        rd_left_next   = LEFT_W'(stat.scan_len) + LEFT_W'(WIN_LEN - 1);
                        state_next     = ST_SCAN;
                    end else begin
                        load_cnt_next = load_cnt_reg + ADDR_W'(1);
                    end
                end
            end
            ST_SCAN: begin
                cmd.rd_en = stat.adv;
                if (stat.adv) begin
                    if (CNT_W'(rd_addr_reg) == stat.scan_len - CNT_W'(1)) begin
                        rd_addr_next = '0;
                    end else begin
                        rd_addr_next = rd_addr_reg + ADDR_W'(1);
                    end
                    rd_left_next = rd_left_reg - LEFT_W'(1);
                    if (rd_left_reg == LEFT_W'(1)) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (stat.last_xfer) begin
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

endmodule

// File: hw/rtl/cmsf_dp.sv
// Datapath of the circular median scan filter: scan memory, sliding window, median select,
// result register and the ray_count register. Depends on cmsf_pkg; commanded by cmsf_ctrl.
module cmsf_dp
    import cmsf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CNT_W-1:0]    cfg_wr_data,
    input  logic [SAMPLE_W-1:0] s_range_sample,
    input  cmsf_cmd_t           cmd,
    output cmsf_stat_t          stat,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SAMPLE_W-1:0] m_filtered_range,
    output logic [ADDR_W-1:0]   m_ray_index,
    output logic                m_last_of_scan
);

    logic [SAMPLE_W-1:0] mem [MAX_RAYS];

    logic [CNT_W-1:0]    ray_count_reg;
    logic [CNT_W-1:0]    scan_len;
    logic                adv;

    logic [SAMPLE_W-1:0] rdata_reg;
    logic                rv_reg;
    logic [SAMPLE_W-1:0] win_reg [WIN_LEN];
    logic [WC_W-1:0]     win_cnt_reg;
    logic                wv_reg;
    logic [ADDR_W-1:0]   ray_cnt_reg;

    logic [SAMPLE_W-1:0] out_data_reg;
    logic [ADDR_W-1:0]   out_idx_reg;
    logic                out_last_reg;
    logic                out_valid_reg;

    logic [SAMPLE_W-1:0] median;

    // saturate the register to the supported scan lengths
    always_comb begin
        if (ray_count_reg < CNT_W'(MIN_RAYS)) begin
            scan_len = CNT_W'(MIN_RAYS);
        end else if (ray_count_reg > CNT_W'(MAX_RAYS)) begin
            scan_len = CNT_W'(MAX_RAYS);
        end else begin
            scan_len = ray_count_reg;
        end
    end

    assign adv = !out_valid_reg || m_ready;

    assign stat.scan_len  = scan_len;
    assign stat.adv       = adv;
    assign stat.last_xfer = out_valid_reg && m_ready && out_last_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ray_count_reg <= RAY_COUNT_RESET;
        end else if (cfg_wr_en) begin
            ray_count_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr] <= s_range_sample;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && cmd.rd_en) begin
            rdata_reg <= mem[cmd.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && rv_reg) begin
            for (int i = 0; i < WIN_LEN - 1; i++) begin
                win_reg[i] <= win_reg[i+1];
            end
            win_reg[WIN_LEN-1] <= rdata_reg;
        end
    end

    // rank each window entry; ties broken by position so exactly one entry has the middle rank
    always_comb begin
        logic [RANK_W-1:0] rank;
        median = win_reg[0];
        for (int i = 0; i < WIN_LEN; i++) begin
            rank = '0;
            for (int j = 0; j < WIN_LEN; j++) begin
                if (j < i) begin
                    if (win_reg[j] <= win_reg[i]) rank = rank + RANK_W'(1);
                end else if (j > i) begin
                    if (win_reg[j] < win_reg[i]) rank = rank + RANK_W'(1);
                end
            end
            if (rank == RANK_W'(HALF_WINDOW)) begin
                median = win_reg[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg        <= 1'b0;
            wv_reg        <= 1'b0;
            win_cnt_reg   <= '0;
            ray_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else if (cmd.scan_start) begin
            win_cnt_reg <= '0;
            ray_cnt_reg <= '0;
        end else if (adv) begin
            rv_reg        <= cmd.rd_en;
            wv_reg        <= rv_reg && (win_cnt_reg >= WC_W'(WIN_LEN - 1));
            out_valid_reg <= wv_reg;
            if (rv_reg && (win_cnt_reg < WC_W'(WIN_LEN))) begin
                win_cnt_reg <= win_cnt_reg + WC_W'(1);
            end
            if (wv_reg) begin
                ray_cnt_reg <= ray_cnt_reg + ADDR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && wv_reg) begin
            out_data_reg <= median;
            out_idx_reg  <= ray_cnt_reg;
            out_last_reg <= (CNT_W'(ray_cnt_reg) == scan_len - CNT_W'(1));
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_filtered_range = out_data_reg;
    assign m_ray_index      = out_idx_reg;
    assign m_last_of_scan   = out_last_reg;

endmodule

// File: hw/rtl/circular_median5_scan_filter.sv
// Top level of the circular five-sample median filter for one range scan.
// Depends on cmsf_pkg; instantiates cmsf_ctrl and cmsf_dp.
//
// Samples are taken one per cycle into a 64-entry scan memory until the scan
// length (ray_count, saturated to 5..64) is reached. The transfer that completes
// the scan starts a burst: the memory's single read port walks the scan from
// entry n-2, wrapping, with n+4 reads, a five-tap window slides over the data, and
// one median per ray leaves through a result register, ray 0 first. No sample
// is taken from the start of the burst until the last result has been
// transferred, so a scan of n rays costs n loads, then n+4 reads at one read per
// cycle of the scan memory while the output is not stalled, plus the read, window
// and result register stages.
// ray_count may be written only while no scan is being emitted.
module circular_median5_scan_filter
    import cmsf_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CNT_W-1:0]    cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [SAMPLE_W-1:0] s_range_sample,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [SAMPLE_W-1:0] m_filtered_range,
    output logic [ADDR_W-1:0]   m_ray_index,
    output logic                m_last_of_scan
);

    cmsf_cmd_t  cmd;
    cmsf_stat_t stat;

    cmsf_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    cmsf_dp u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_range_sample   (s_range_sample),
        .cmd              (cmd),
        .stat             (stat),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_filtered_range (m_filtered_range),
        .m_ray_index      (m_ray_index),
        .m_last_of_scan   (m_last_of_scan)
    );

endmodule
